// ===== design/nps_pkg.sv =====
package nps_pkg;

    localparam int MAX_JOBS  = 64;
    localparam int TIME_BITS = 16;
    localparam int IDX_W     = $clog2(MAX_JOBS);
    localparam int CNT_W     = $clog2(MAX_JOBS + 1);
    localparam int FLD_W     = 16;
    localparam int PRIO_W    = 8;
    localparam int ID_W      = 6;
    localparam int CMP_W     = (TIME_BITS > FLD_W) ? TIME_BITS : FLD_W;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [FLD_W-1:0]  arrival;
        logic [FLD_W-1:0]  burst_len;
        logic [PRIO_W-1:0] prio;
    } t_job;

    typedef struct packed {
        logic              found;
        logic [PRIO_W-1:0] prio;
        logic [FLD_W-1:0]  arrival;
        logic [FLD_W-1:0]  burst_len;
        logic [IDX_W-1:0]  idx;
    } t_cand;

    typedef struct packed {
        logic              all_done;
        logic [FLD_W-1:0]  turnaround;
        logic              finished;
        logic [FLD_W-1:0]  waiting;
        logic              dispatched;
        logic [ID_W-1:0]   running_id;
        logic              busy_res;
        logic [FLD_W-1:0]  time_now;
        logic              load_rejected;
        logic [ID_W-1:0]   load_id;
    } t_result;

endpackage

// ===== design/nps_cell.sv =====
module nps_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [nps_pkg::IDX_W-1:0]  i_idx,
    input  logic                       i_wr_en,
    input  nps_pkg::t_job              i_job,
    input  logic                       i_clr,
    input  logic [nps_pkg::TIME_BITS-1:0] i_time,
    input  nps_pkg::t_cand             i_cand,
    output nps_pkg::t_cand             o_cand
);
    import nps_pkg::*;

    t_job  r_job;
    logic  r_pend;
    t_cand r_cand;
    logic  elig;
    logic  take;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (i_wr_en) begin
            r_pend <= 1'b1;
        end else if (i_clr) begin
            r_pend <= 1'b0;
        end
    end

    always_comb begin
        elig = r_pend && (CMP_W'(r_job.arrival) <= CMP_W'(i_time));
        take = elig && (!i_cand.found || (r_job.prio < i_cand.prio) ||
               ((r_job.prio == i_cand.prio) && (r_job.arrival < i_cand.arrival)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand <= '0;
        end else if (take) begin
            r_cand.found     <= 1'b1;
            r_cand.prio      <= r_job.prio;
            r_cand.arrival   <= r_job.arrival;
            r_cand.burst_len <= r_job.burst_len;
            r_cand.idx       <= i_idx;
        end else begin
            r_cand <= i_cand;
        end
    end

    assign o_cand = r_cand;

endmodule

// ===== design/nps_chain.sv =====
module nps_chain (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [nps_pkg::IDX_W-1:0]     i_wr_idx,
    input  nps_pkg::t_job                 i_wr_job,
    input  logic                          i_clr_en,
    input  logic [nps_pkg::IDX_W-1:0]     i_clr_idx,
    input  logic [nps_pkg::TIME_BITS-1:0] i_time,
    output nps_pkg::t_cand                o_best
);
    import nps_pkg::*;

    t_cand cand [MAX_JOBS+1];
    t_job  wr_job;

    always_comb begin
        wr_job = i_wr_job;
        if (i_wr_job.burst_len == '0) begin
            wr_job.burst_len = FLD_W'(1);
        end
    end

    assign cand[0] = '0;

    for (genvar k = 0; k < MAX_JOBS; k++) begin : g_cell
        nps_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(k)),
            .i_wr_en (i_wr_en && (i_wr_idx == IDX_W'(k))),
            .i_job   (wr_job),
            .i_clr   (i_clr_en && (i_clr_idx == IDX_W'(k))),
            .i_time  (i_time),
            .i_cand  (cand[k]),
            .o_cand  (cand[k+1])
        );
    end

    assign o_best = cand[MAX_JOBS];

endmodule

// ===== design/nonpreemptive_priority_scheduler.sv =====
// A load transaction has its result registered at its accepting edge.
// A tick while a job runs goes straight to the finish state, which registers its result once
// the output is free. A tick while idle first passes through the scan state, in which the
// selection candidate walks the job cells one per cycle, and then through the finish state.
// One transaction is in work at a time; a stalled result register holds off the next one.
// Synchronous active-low reset clears the job count, pending flags, tick counter and state.
module nonpreemptive_priority_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // arrival[15:0], burst_len[31:16], prio[39:32]
    input  logic [0:0]  s_axis_tuser,  // mode[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // load_id[5:0], load_rejected[6], time_now[22:7], busy_res[23], running_id[29:24],
    // dispatched[30], waiting[46:31], finished[47], turnaround[63:48], all_done[64]
    output logic [71:0] m_axis_tdata
);
    import nps_pkg::*;

    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_cnt, n_cnt;
    logic [TIME_BITS-1:0]  r_clock, n_clock;
    logic                  r_busy, n_busy;
    logic [IDX_W-1:0]      r_cur, n_cur;
    logic [FLD_W-1:0]      r_rem, n_rem;
    logic [FLD_W-1:0]      r_cur_arr, n_cur_arr;
    logic [CNT_W-1:0]      r_loaded, n_loaded;
    logic [CNT_W-1:0]      r_npend, n_npend;
    logic                  r_out_valid, n_out_valid;
    t_result               r_res, n_res;

    logic                  acc_in;
    logic                  is_tick;
    logic                  out_free;
    logic                  commit_tick;
    logic                  wr_en;
    logic                  clr_en;
    t_job                  in_job;
    t_cand                 best;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && out_free;
    assign acc_in        = s_axis_tvalid && s_axis_tready;
    assign is_tick       = (s_axis_tuser[0] == MODE_TICK);
    assign commit_tick   = (r_state == ST_FIN) && out_free;
    assign wr_en         = acc_in && !is_tick && (r_loaded < CNT_W'(MAX_JOBS));
    assign clr_en        = commit_tick && !r_busy && best.found;

    assign in_job.arrival   = s_axis_tdata[15:0];
    assign in_job.burst_len = s_axis_tdata[31:16];
    assign in_job.prio      = s_axis_tdata[39:32];

    nps_chain u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_idx  (r_loaded[IDX_W-1:0]),
        .i_wr_job  (in_job),
        .i_clr_en  (clr_en),
        .i_clr_idx (best.idx),
        .i_time    (r_clock),
        .o_best    (best)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc_in && is_tick) begin
                    n_state = r_busy ? ST_FIN : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_cnt == IDX_W'(MAX_JOBS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        logic                 run;
        logic                 disp;
        logic [FLD_W-1:0]     arr;
        logic [FLD_W-1:0]     rem;
        logic [TIME_BITS-1:0] wait_t;
        logic [TIME_BITS:0]   ta_w;
        logic [TIME_BITS-1:0] ta;

        n_cnt       = (r_state == ST_SCAN) ? r_cnt + IDX_W'(1) : '0;
        n_clock     = r_clock;
        n_busy      = r_busy;
        n_cur       = r_cur;
        n_rem       = r_rem;
        n_cur_arr   = r_cur_arr;
        n_loaded    = r_loaded;
        n_npend     = r_npend;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_res       = r_res;

        disp   = !r_busy && best.found;
        run    = r_busy || disp;
        arr    = disp ? best.arrival : r_cur_arr;
        rem    = disp ? best.burst_len : r_rem;
        wait_t = r_clock - TIME_BITS'(arr);
        ta_w   = {1'b0, r_clock} + (TIME_BITS+1)'(1) - (TIME_BITS+1)'(arr);
        ta     = (ta_w > {1'b0, TIME_MAX}) ? TIME_MAX : ta_w[TIME_BITS-1:0];

        if (acc_in && !is_tick) begin
            n_out_valid = 1'b1;
            n_res       = '0;
            if (wr_en) begin
                n_loaded      = r_loaded + CNT_W'(1);
                n_npend       = r_npend + CNT_W'(1);
                n_res.load_id = ID_W'(r_loaded);
            end else begin
                n_res.load_rejected = 1'b1;
            end
        end

        if (commit_tick) begin
            n_out_valid    = 1'b1;
            n_res          = '0;
            n_res.time_now = FLD_W'(r_clock);
            if (disp) begin
                n_npend          = r_npend - CNT_W'(1);
                n_cur            = best.idx;
                n_cur_arr        = best.arrival;
                n_res.dispatched = 1'b1;
                n_res.waiting    = FLD_W'(wait_t);
            end
            if (run) begin
                n_res.busy_res   = 1'b1;
                n_res.running_id = ID_W'(disp ? best.idx : r_cur);
                if (rem <= FLD_W'(1)) begin
                    n_rem            = '0;
                    n_busy           = 1'b0;
                    n_res.finished   = 1'b1;
                    n_res.turnaround = FLD_W'(ta);
                end else begin
                    n_rem  = rem - FLD_W'(1);
                    n_busy = 1'b1;
                end
            end else begin
                n_busy = 1'b0;
            end
            n_res.all_done = (n_npend == '0) && !n_busy;
            n_clock        = (r_clock == TIME_MAX) ? r_clock : r_clock + TIME_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_clock     <= '0;
            r_busy      <= 1'b0;
            r_cur       <= '0;
            r_loaded    <= '0;
            r_npend     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_clock     <= n_clock;
            r_busy      <= n_busy;
            r_cur       <= n_cur;
            r_loaded    <= n_loaded;
            r_npend     <= n_npend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_cur_arr <= n_cur_arr;
        r_res     <= n_res;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_res};

    a_loaded_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded <= CNT_W'(MAX_JOBS))
        else $error("Job count exceeds the table size.");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_npend <= r_loaded)
        else $error("Pending count exceeds the loaded job count.");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_state == ST_IDLE))
        else $error("Input taken outside the idle state.");

    a_idle_tick_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && is_tick && !r_busy) |=> (r_state == ST_SCAN) && (r_cnt == '0))
        else $error("Idle tick did not start a selection pass.");

    a_disp_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_en |=> r_busy || r_res.finished)
        else $error("Dispatch left the block without a running job.");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import nps_pkg::*;

    localparam int   RND_ITEMS      = 2000;
    localparam int   RAND_JOB_CAP   = 58;
    localparam int   RX_HOLD        = 300;
    localparam int   WATCHDOG_LIMIT = 4000;
    localparam int   RES_W          = $bits(t_result);

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // arrival[15:0], burst_len[31:16], prio[39:32]
    logic [0:0]  s_axis_tuser;   // mode[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // load_id[5:0], load_rejected[6], time_now[22:7], busy_res[23], running_id[29:24],
    // dispatched[30], waiting[46:31], finished[47], turnaround[63:48], all_done[64]
    logic [71:0] m_axis_tdata;

    always #4 i_clk = ~i_clk;

    nonpreemptive_priority_scheduler i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    logic [15:0] job_arrival [MAX_JOBS];
    logic [15:0] job_left    [MAX_JOBS];
    logic [7:0]  job_prio    [MAX_JOBS];
    bit          job_pending [MAX_JOBS];
    int          jobs_in_table = 0;
    int          tick_now      = 0;
    bit          cpu_busy      = 1'b0;
    int          cpu_job       = 0;

    t_result     expected_results[$];
    int          n_errors     = 0;
    int          stall_cycles = 0;
    bit          tx_idle      = 1'b1;
    bit          rx_idle      = 1'b1;
    bit          rx_hold_req  = 1'b0;

    function automatic t_result schedule_step(input logic mode, input logic [15:0] arr,
                                              input logic [15:0] blen, input logic [7:0] pr);
        t_result r;
        int      i;
        int      best;
        int      ta;
        bit      found;
        bit      any_left;
        r        = '0;
        best     = 0;
        found    = 1'b0;
        any_left = 1'b0;
        if (mode == MODE_LOAD) begin
            if (jobs_in_table >= MAX_JOBS) begin
                r.load_rejected = 1'b1;
            end else begin
                job_arrival[jobs_in_table] = arr;
                job_left[jobs_in_table]    = (blen == 16'd0) ? 16'd1 : blen;
                job_prio[jobs_in_table]    = pr;
                job_pending[jobs_in_table] = 1'b1;
                r.load_id = ID_W'(jobs_in_table);
                jobs_in_table++;
            end
        end else begin
            r.time_now = 16'(tick_now);
            if (!cpu_busy) begin
                for (i = 0; i < MAX_JOBS; i++) begin
                    if (job_pending[i] && job_arrival[i] <= tick_now) begin
                        if (!found || job_prio[i] < job_prio[best] ||
                            (job_prio[i] == job_prio[best] &&
                             job_arrival[i] < job_arrival[best])) begin
                            best  = i;
                            found = 1'b1;
                        end
                    end
                end
                if (found) begin
                    cpu_busy          = 1'b1;
                    cpu_job           = best;
                    job_pending[best] = 1'b0;
                    r.dispatched      = 1'b1;
                    r.waiting         = 16'(tick_now - job_arrival[best]);
                end
            end
            if (cpu_busy) begin
                r.busy_res   = 1'b1;
                r.running_id = ID_W'(cpu_job);
                if (job_left[cpu_job] <= 16'd1) begin
                    ta = tick_now + 1 - job_arrival[cpu_job];
                    if (ta > TIME_MAX) begin
                        ta = TIME_MAX;
                    end
                    job_left[cpu_job] = 16'd0;
                    r.finished        = 1'b1;
                    r.turnaround      = 16'(ta);
                    cpu_busy          = 1'b0;
                end else begin
                    job_left[cpu_job] = job_left[cpu_job] - 16'd1;
                end
            end
            for (i = 0; i < MAX_JOBS; i++) begin
                if (job_pending[i]) begin
                    any_left = 1'b1;
                end
            end
            r.all_done = !any_left && !cpu_busy;
            if (tick_now < TIME_MAX) begin
                tick_now++;
            end
        end
        return r;
    endfunction

    function automatic bit table_idle();
        int i;
        bit idle;
        idle = !cpu_busy;
        for (i = 0; i < MAX_JOBS; i++) begin
            if (job_pending[i]) begin
                idle = 1'b0;
            end
        end
        return idle;
    endfunction

    function automatic string format_result(input t_result r);
        return $sformatf({"id=%0d rej=%0d t=%0d busy=%0d run=%0d disp=%0d wait=%0d ",
                          "fin=%0d ta=%0d done=%0d"},
                         r.load_id, r.load_rejected, r.time_now, r.busy_res, r.running_id,
                         r.dispatched, r.waiting, r.finished, r.turnaround, r.all_done);
    endfunction

    task automatic send_item(input logic mode, input logic [15:0] arr,
                             input logic [15:0] blen, input logic [7:0] pr);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        expected_results.push_back(schedule_step(mode, arr, blen, pr));
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {pr, blen, arr};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_tick();
        send_item(MODE_TICK, 16'($urandom), 16'($urandom), 8'($urandom));
    endtask

    // Covers both tie-break rules, a zero burst, one-tick jobs and idle ticks before arrival.
    task automatic test_directed_order();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_item(MODE_LOAD, 16'd0, 16'd0, 8'd5);
        send_item(MODE_LOAD, 16'd0, 16'd1, 8'd5);
        send_item(MODE_LOAD, 16'd1, 16'd2, 8'd0);
        send_item(MODE_LOAD, 16'd0, 16'd3, 8'hFF);
        repeat (8) send_tick();
        send_item(MODE_LOAD, 16'd11, 16'd2, 8'd9);
        send_item(MODE_LOAD, 16'd10, 16'd1, 8'd9);
        send_item(MODE_LOAD, 16'd10, 16'd1, 8'd9);
        repeat (7) send_tick();
    endtask

    task automatic test_random_traffic(input int n_items);
        int          sent;
        int          next_shuffle;
        int          n_loads;
        int          k;
        bit          hold_issued;
        logic [15:0] arr;
        logic [15:0] blen;
        logic [7:0]  pr;
        sent         = 0;
        next_shuffle = 0;
        hold_issued  = 1'b0;
        while (sent < n_items) begin
            if (sent >= next_shuffle) begin
                tx_idle      = ($urandom_range(0, 3) != 0);
                rx_idle      = ($urandom_range(0, 3) != 0);
                next_shuffle = next_shuffle + 200;
            end
            if (!hold_issued && sent >= n_items / 4) begin
                rx_hold_req = 1'b1;
                hold_issued = 1'b1;
            end
            if (jobs_in_table < RAND_JOB_CAP && $urandom_range(0, 24) == 0) begin
                n_loads = $urandom_range(1, 4);
                for (k = 0; k < n_loads && jobs_in_table < RAND_JOB_CAP; k++) begin
                    case ($urandom_range(0, 19))
                        0: arr = 16'(tick_now + $urandom_range(31, 500));
                        1, 2, 3: arr = (tick_now > 30) ? 16'(tick_now - $urandom_range(0, 30))
                                                       : 16'd0;
                        default: arr = 16'(tick_now + $urandom_range(0, 30));
                    endcase
                    blen = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 1))
                                                       : 16'($urandom_range(1, 12));
                    pr   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
                    send_item(MODE_LOAD, arr, blen, pr);
                    sent++;
                end
            end else begin
                send_tick();
                sent++;
            end
        end
    endtask

    task automatic test_full_table();
        int k;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        while (jobs_in_table < MAX_JOBS) begin
            send_item(MODE_LOAD, 16'(tick_now + $urandom_range(0, 20)),
                      16'($urandom_range(1, 3)), 8'($urandom));
        end
        for (k = 0; k < 12; k++) begin
            send_item(MODE_LOAD, 16'($urandom), 16'($urandom), 8'($urandom));
            send_tick();
        end
        while (!table_idle()) begin
            send_tick();
        end
        send_tick();
    endtask

    initial begin : result_checker
        int      w;
        t_result got;
        t_result want;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            w = rx_idle ? $urandom_range(0, 15) : 0;
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                w = w + RX_HOLD;
            end
            if (w > 0) begin
                m_axis_tready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got = m_axis_tdata[RES_W-1:0];
            if (expected_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("Unexpected result transaction: %s", format_result(got));
                end
            end else begin
                want = expected_results.pop_front();
                if (got !== want || m_axis_tdata[71:RES_W] !== '0) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("Mismatch at %0t\n  expected %s pad=0\n  actual   %s pad=%h",
                                 $realtime, format_result(want), format_result(got),
                                 m_axis_tdata[71:RES_W]);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_order();
        test_random_traffic(RND_ITEMS);
        test_full_table();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/nps_pkg.sv
design/nps_cell.sv
design/nps_chain.sv
design/nonpreemptive_priority_scheduler.sv
test/tb_top.sv
